// ----- rtl/lmad_pkg.sv -----
package lmad_pkg;

	localparam int LUX_W      = 23;
	localparam int SAMPLE_W   = 24;
	localparam int PCT_W      = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 23;

	localparam int MEDIAN_TAPS_DEF    = 5;
	localparam int AVERAGE_WINDOW_DEF = 5;

	localparam logic [LUX_W-1:0] LUX_MAX    = 23'd6400000;
	localparam logic [PCT_W-1:0] FULL_SCALE = 11'd1600;

	localparam logic [LUX_W-1:0] DARK_RST   = 23'd3200;
	localparam logic [LUX_W-1:0] BRIGHT_RST = 23'd19200;
	localparam logic [PCT_W-1:0] BAND_RST   = 11'd80;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DARK   = 2'd0,
		CFG_BRIGHT = 2'd1,
		CFG_BAND   = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MED,
		ST_AVG,
		ST_MAP,
		ST_DONE
	} top_state_t;

	typedef enum logic [2:0] {
		MAP_IDLE,
		MAP_MUL1,
		MAP_MUL2,
		MAP_DIV,
		MAP_HYST,
		MAP_DONE
	} map_state_t;

endpackage

// ----- rtl/lmad_if.sv -----
interface lmad_in_if import lmad_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic                       sample_ready;
	logic signed [SAMPLE_W-1:0] lux_sample;

	modport source (output valid, output sample_ready, output lux_sample, input ready);
	modport sink (input valid, input sample_ready, input lux_sample, output ready);
endinterface

interface lmad_out_if import lmad_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             accepted;
	logic [LUX_W-1:0] filtered_lux;
	logic [PCT_W-1:0] brightness_pct;

	modport source (output valid, output accepted, output filtered_lux,
		output brightness_pct, input ready);
	modport sink (input valid, input accepted, input filtered_lux,
		input brightness_pct, output ready);
endinterface

interface lmad_cfg_if import lmad_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/lmad_median.sv -----
module lmad_median import lmad_pkg::*; #(
	parameter int TAPS = MEDIAN_TAPS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [LUX_W-1:0] sample,
	output unit_stat_t       stat,
	output logic [LUX_W-1:0] median
);

	localparam int CNT_W  = $clog2(TAPS + 1);
	localparam int STEP_W = $clog2(LUX_W);
	localparam logic [CNT_W-1:0]  RANK      = CNT_W'(TAPS / 2);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(LUX_W - 1);

	logic [LUX_W-1:0]  hist_q [TAPS];
	logic [LUX_W-1:0]  hist_next [TAPS];
	logic [LUX_W-1:0]  work_q [TAPS];
	logic [TAPS-1:0]   active_q;
	logic [TAPS-1:0]   msb;
	logic [CNT_W-1:0]  krem_q;
	logic [CNT_W-1:0]  zeros;
	logic              take_one;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [LUX_W-1:0]  med_q;

	always_comb begin
		hist_next[0] = sample;
		for (int i = 1; i < TAPS; i++) begin
			hist_next[i] = hist_q[i-1];
		end
		for (int i = 0; i < TAPS; i++) begin
			msb[i] = work_q[i][LUX_W-1];
		end
	end

	// rank select, MSB first: the digit is 0 if enough live candidates carry a 0
	assign zeros    = CNT_W'($countones(active_q & ~msb));
	assign take_one = (krem_q >= zeros);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			for (int i = 0; i < TAPS; i++) begin
				hist_q[i] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				hist_q <= hist_next;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q   <= hist_next;
			active_q <= '1;
			krem_q   <= RANK;
		end else if (busy_q) begin
			for (int i = 0; i < TAPS; i++) begin
				work_q[i] <= {work_q[i][LUX_W-2:0], 1'b0};
			end
			if (take_one) begin
				active_q <= active_q & msb;
				krem_q   <= krem_q - zeros;
			end else begin
				active_q <= active_q & ~msb;
			end
			med_q <= {med_q[LUX_W-2:0], take_one};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign median    = med_q;

endmodule

// ----- rtl/lmad_average.sv -----
module lmad_average import lmad_pkg::*; #(
	parameter int WIN = AVERAGE_WINDOW_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [LUX_W-1:0] value,
	output unit_stat_t       stat,
	output logic [LUX_W-1:0] average
);

	localparam int IDX_W  = (WIN > 1) ? $clog2(WIN) : 1;
	localparam int HI_W   = $clog2(WIN + 1);
	localparam int SUM_W  = LUX_W + HI_W;
	localparam int REM_W  = HI_W + 1;
	localparam int STEP_W = $clog2(LUX_W);
	localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(WIN - 1);
	localparam logic [REM_W-1:0]  DIVISOR   = REM_W'(WIN);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(LUX_W - 1);

	logic [LUX_W-1:0]  ring_q [WIN];
	logic [IDX_W-1:0]  idx_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SUM_W-1:0]  sum_next;
	logic [HI_W-1:0]   rem_q;
	logic [LUX_W-1:0]  lo_q;
	logic [LUX_W-1:0]  quo_q;
	logic [REM_W-1:0]  trial;
	logic [REM_W-1:0]  trial_sub;
	logic              fits;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;

	// running sum: add the new entry, drop the one it overwrites
	assign sum_next  = sum_q + SUM_W'(value) - SUM_W'(ring_q[idx_q]);
	assign trial     = {rem_q, lo_q[LUX_W-1]};
	assign fits      = (trial >= DIVISOR);
	assign trial_sub = trial - DIVISOR;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			idx_q  <= '0;
			sum_q  <= '0;
			quo_q  <= '0;
			for (int i = 0; i < WIN; i++) begin
				ring_q[i] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			if (start) begin
				ring_q[idx_q] <= value;
				idx_q         <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
				sum_q         <= sum_next;
				busy_q        <= 1'b1;
				step_q        <= '0;
			end else if (busy_q) begin
				quo_q  <= {quo_q[LUX_W-2:0], fits};
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// the top part of the sum is already below the window size
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= sum_next[SUM_W-1:LUX_W];
			lo_q  <= sum_next[LUX_W-1:0];
		end else if (busy_q) begin
			rem_q <= fits ? trial_sub[HI_W-1:0] : trial[HI_W-1:0];
			lo_q  <= {lo_q[LUX_W-2:0], 1'b0};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign average   = quo_q;

endmodule

// ----- rtl/lmad_map.sv -----
module lmad_map import lmad_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [LUX_W-1:0] lux,
	input  logic [LUX_W-1:0] dark,
	input  logic [LUX_W-1:0] bright,
	input  logic [PCT_W-1:0] band,
	output unit_stat_t       stat,
	output logic [PCT_W-1:0] held
);

	localparam int PROD_W = LUX_W + 5;
	localparam int STEP_W = $clog2(PCT_W);
	localparam int LOW_W  = 5;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PCT_W - 1);

	map_state_t        state_q;
	map_state_t        state_next;
	logic              le_dark;
	logic              ge_bright;
	logic [LUX_W-1:0]  x_q;
	logic [LUX_W-1:0]  d_q;
	logic [PROD_W-1:0] p_q;
	logic [PROD_W-1:0] p25;
	logic [LUX_W-1:0]  rem_q;
	logic [PCT_W-1:0]  lo_q;
	logic [PCT_W-1:0]  quo_q;
	logic [PCT_W-1:0]  pct_q;
	logic [PCT_W-1:0]  held_q;
	logic [PCT_W-1:0]  diff;
	logic [LUX_W:0]    trial;
	logic [LUX_W:0]    trial_sub;
	logic              fits;
	logic [STEP_W-1:0] step_q;

	assign le_dark   = (lux <= dark);
	assign ge_bright = (lux >= bright);

	// x*1600 = (x*25) << 6; the divide starts from the bits above the low 11
	assign p25       = p_q + {1'b0, x_q, 4'b0};
	assign trial     = {rem_q, lo_q[PCT_W-1]};
	assign fits      = (trial >= {1'b0, d_q});
	assign trial_sub = trial - {1'b0, d_q};
	assign diff      = (pct_q > held_q) ? pct_q - held_q : held_q - pct_q;

	always_comb begin
		state_next = state_q;
		case (state_q)
			MAP_IDLE: begin
				if (start) begin
					state_next = (le_dark || ge_bright) ? MAP_HYST : MAP_MUL1;
				end
			end
			MAP_MUL1: state_next = MAP_MUL2;
			MAP_MUL2: state_next = MAP_DIV;
			MAP_DIV: begin
				if (step_q == LAST_STEP) begin
					state_next = MAP_HYST;
				end
			end
			MAP_HYST: state_next = MAP_DONE;
			MAP_DONE: state_next = MAP_IDLE;
			default:  state_next = MAP_IDLE;
		endcase
	end

	always_comb begin
		stat.busy = (state_q != MAP_IDLE);
		stat.done = (state_q == MAP_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MAP_IDLE;
			step_q  <= '0;
			held_q  <= '0;
		end else begin
			state_q <= state_next;
			case (state_q)
				MAP_MUL2: step_q <= '0;
				MAP_DIV:  step_q <= step_q + 1'b1;
				MAP_HYST: begin
					if (diff > band) begin
						held_q <= pct_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			MAP_IDLE: begin
				x_q   <= lux - dark;
				d_q   <= bright - dark;
				pct_q <= le_dark ? '0 : FULL_SCALE;
			end
			MAP_MUL1: p_q <= {5'b0, x_q} + {2'b0, x_q, 3'b0};
			MAP_MUL2: begin
				rem_q <= p25[PROD_W-1:LOW_W];
				lo_q  <= {p25[LOW_W-1:0], 6'b0};
			end
			MAP_DIV: begin
				rem_q <= fits ? trial_sub[LUX_W-1:0] : trial[LUX_W-1:0];
				lo_q  <= {lo_q[PCT_W-2:0], 1'b0};
				quo_q <= {quo_q[PCT_W-2:0], fits};
				if (step_q == LAST_STEP) begin
					pct_q <= {quo_q[PCT_W-2:0], fits};
				end
			end
			default: ;
		endcase
	end

	assign held = held_q;

endmodule

// ----- rtl/lux_median_average_dimmer.sv -----
// Light sample smoother and dimmer. Each request carries a ready flag and a
// signed lux sample in 1/64 lux; a sample that is not ready, negative or above
// 100000 lux is answered with accepted low and the last filtered lux and
// brightness repeated, the result loading from the done state once the output
// register is free. An in-range sample runs through a median over the last
// MEDIAN_TAPS samples, a moving average over the last AVERAGE_WINDOW medians
// and a linear map to 0..1600 (1/16 percent) with a hysteresis hold. Its
// result passes the 23 bit steps of the radix median select and the handoff,
// the ring update and the 23 steps of the bit-serial divide by the window
// size, the shift-add scaling, 11-step brightness divide, hysteresis compare
// and handoff, and the load of the result register. A filtered lux at or
// beyond a threshold skips the scaling and divide. One request is in flight at
// a time; the next is taken once the result has loaded and the block is back
// in idle, and a held result that waits for ready holds off the next request.
// Thresholds and band are written over the cfg channel, which is always ready;
// write them only while no request is in flight.
module lux_median_average_dimmer import lmad_pkg::*; #(
	parameter int MEDIAN_TAPS    = MEDIAN_TAPS_DEF,
	parameter int AVERAGE_WINDOW = AVERAGE_WINDOW_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	lmad_in_if.sink   sample_in,
	lmad_out_if.source result_out,
	lmad_cfg_if.sink  cfg
);

	top_state_t       state_q;
	top_state_t       state_next;
	logic [LUX_W-1:0] dark_q;
	logic [LUX_W-1:0] bright_q;
	logic [PCT_W-1:0] band_q;
	logic             in_fire;
	logic             sample_ok;
	logic             med_start;
	logic             avg_start;
	logic             map_start;
	logic             out_load;
	logic             in_ready;
	unit_stat_t       med_stat;
	unit_stat_t       avg_stat;
	unit_stat_t       map_stat;
	logic [LUX_W-1:0] med_value;
	logic [LUX_W-1:0] avg_value;
	logic [PCT_W-1:0] held_value;
	logic             acc_q;
	logic             out_valid_q;
	logic             out_acc_q;
	logic [LUX_W-1:0] out_lux_q;
	logic [PCT_W-1:0] out_pct_q;

	assign in_fire   = sample_in.valid && in_ready;
	assign sample_ok = sample_in.sample_ready && !sample_in.lux_sample[SAMPLE_W-1]
		&& (sample_in.lux_sample[LUX_W-1:0] <= LUX_MAX);

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_next = sample_ok ? ST_MED : ST_DONE;
				end
			end
			ST_MED: begin
				if (med_stat.done) begin
					state_next = ST_AVG;
				end
			end
			ST_AVG: begin
				if (avg_stat.done) begin
					state_next = ST_MAP;
				end
			end
			ST_MAP: begin
				if (map_stat.done) begin
					state_next = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == ST_IDLE) && !med_stat.busy && !avg_stat.busy
			&& !map_stat.busy;
		med_start = (state_q == ST_IDLE) && in_fire && sample_ok;
		avg_start = (state_q == ST_MED) && med_stat.done;
		map_start = (state_q == ST_AVG) && avg_stat.done;
		out_load  = (state_q == ST_DONE) && (!out_valid_q || result_out.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			dark_q      <= DARK_RST;
			bright_q    <= BRIGHT_RST;
			band_q      <= BAND_RST;
		end else begin
			state_q <= state_next;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg.valid) begin
				case (cfg.index)
					CFG_DARK:   dark_q   <= cfg.data;
					CFG_BRIGHT: bright_q <= cfg.data;
					CFG_BAND:   band_q   <= cfg.data[PCT_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			acc_q <= sample_ok;
		end
		if (out_load) begin
			out_acc_q <= acc_q;
			out_lux_q <= avg_value;
			out_pct_q <= held_value;
		end
	end

	lmad_median #(
		.TAPS(MEDIAN_TAPS)
	) u_median (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (med_start),
		.sample (sample_in.lux_sample[LUX_W-1:0]),
		.stat   (med_stat),
		.median (med_value)
	);

	lmad_average #(
		.WIN(AVERAGE_WINDOW)
	) u_average (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (avg_start),
		.value   (med_value),
		.stat    (avg_stat),
		.average (avg_value)
	);

	lmad_map u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (map_start),
		.lux    (avg_value),
		.dark   (dark_q),
		.bright (bright_q),
		.band   (band_q),
		.stat   (map_stat),
		.held   (held_value)
	);

	assign sample_in.ready         = in_ready;
	assign cfg.ready               = 1'b1;
	assign result_out.valid        = out_valid_q;
	assign result_out.accepted     = out_acc_q;
	assign result_out.filtered_lux = out_lux_q;
	assign result_out.brightness_pct = out_pct_q;

endmodule

// ----- rtl/lmad_checker.sv -----
module lmad_checker import lmad_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	lmad_in_if.sink    sample_in,
	lmad_out_if.source result_out
);

	// one request in flight: ready drops right after an accept
	a_in_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		sample_in.valid && sample_in.ready |=> !sample_in.ready)
		else $error("input accepted while a request is in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid && !result_out.ready |=> result_out.valid)
		else $error("result dropped while stalled");

	a_lux_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid |-> (result_out.filtered_lux <= LUX_MAX))
		else $error("filtered lux above full range");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid |-> (result_out.brightness_pct <= FULL_SCALE))
		else $error("brightness above full scale");

endmodule

bind lux_median_average_dimmer lmad_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.sample_in  (sample_in),
	.result_out (result_out)
);

// ----- tb/tb_lux_median_average_dimmer.sv -----
module tb_lux_median_average_dimmer import lmad_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEMS_PER_PHASE = 128;
	localparam int NUM_FIXED       = 6;
	localparam int NUM_PHASES      = NUM_FIXED + 4;
	localparam int NUM_DIRECTED    = 25;
	localparam int SETTLE_CYCLES   = 100;
	localparam int HOLD_AT         = 300;
	localparam int HOLD_CYCLES     = 400;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int LUX_TOP         = int'(LUX_MAX);

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct {
		logic             accepted;
		logic [LUX_W-1:0] filtered_lux;
		logic [PCT_W-1:0] brightness_pct;
	} lux_reading_t;

	typedef struct {
		logic                rdy;
		logic [SAMPLE_W-1:0] lux;
		logic                typed;
		logic                accepted;
		logic [LUX_W-1:0]    filtered_lux;
		logic [PCT_W-1:0]    brightness_pct;
	} sample_row_t;

	typedef struct {
		logic [CFG_DATA_W-1:0] dark;
		logic [CFG_DATA_W-1:0] bright;
		logic [CFG_DATA_W-1:0] band;
	} dimmer_cfg_t;

	logic clk = 1'b0;
	logic arst_n;

	lmad_in_if  sample_if ();
	lmad_out_if result_if ();
	lmad_cfg_if cfg_if ();

	lux_median_average_dimmer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_in  (sample_if),
		.result_out (result_if),
		.cfg        (cfg_if)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Rows with typed results can be read straight off the rules: rejects after
	// reset repeat zeros, and bright samples in under half the taps cannot move a median of zeros.
	sample_row_t directed_rows [NUM_DIRECTED] = '{
		'{1'b0, 24'd0,       1'b1, 1'b0, 23'd0, 11'd0},
		'{1'b1, 24'hFFFFFF,  1'b1, 1'b0, 23'd0, 11'd0},
		'{1'b1, 24'h800000,  1'b1, 1'b0, 23'd0, 11'd0},
		'{1'b1, 24'h7FFFFF,  1'b1, 1'b0, 23'd0, 11'd0},
		'{1'b1, 24'd6400001, 1'b1, 1'b0, 23'd0, 11'd0},
		'{1'b0, 24'd6400000, 1'b1, 1'b0, 23'd0, 11'd0},
		'{1'b1, 24'd6400000, 1'b1, 1'b1, 23'd0, 11'd0},
		'{1'b1, 24'd0,       1'b1, 1'b1, 23'd0, 11'd0},
		'{1'b1, 24'd6400000, 1'b1, 1'b1, 23'd0, 11'd0},
		'{1'b1, 24'd6400000, 1'b0, 1'b0, 23'd0, 11'd0},
		'{1'b1, 24'd6400000, 1'b0, 1'b0, 23'd0, 11'd0},
		'{1'b1, 24'd6400000, 1'b0, 1'b0, 23'd0, 11'd0},
		'{1'b1, 24'd6400000, 1'b0, 1'b0, 23'd0, 11'd0},
		'{1'b0, 24'd123,     1'b0, 1'b0, 23'd0, 11'd0},
		'{1'b1, 24'hFFF000,  1'b0, 1'b0, 23'd0, 11'd0},
		'{1'b1, 24'd3200,    1'b0, 1'b0, 23'd0, 11'd0},
		'{1'b1, 24'd3200,    1'b0, 1'b0, 23'd0, 11'd0},
		'{1'b1, 24'd3200,    1'b0, 1'b0, 23'd0, 11'd0},
		'{1'b1, 24'd3200,    1'b0, 1'b0, 23'd0, 11'd0},
		'{1'b1, 24'd3201,    1'b0, 1'b0, 23'd0, 11'd0},
		'{1'b1, 24'd11200,   1'b0, 1'b0, 23'd0, 11'd0},
		'{1'b1, 24'd11200,   1'b0, 1'b0, 23'd0, 11'd0},
		'{1'b1, 24'd11200,   1'b0, 1'b0, 23'd0, 11'd0},
		'{1'b1, 24'd19199,   1'b0, 1'b0, 23'd0, 11'd0},
		'{1'b1, 24'd19200,   1'b0, 1'b0, 23'd0, 11'd0}
	};

	dimmer_cfg_t fixed_cfg [NUM_FIXED] = '{
		'{23'd0,       23'd6400000, 23'd0},
		'{23'd16000,   23'd16000,   23'd1600},
		'{23'd6400000, 23'd0,       23'h7FFFFF},
		'{23'd0,       23'd1,       23'd0},
		'{23'h7FFFFF,  23'd0,       23'd5},
		'{23'd3200,    23'd19200,   23'd80}
	};

	// Predictor state and its copy of the registers
	logic [LUX_W-1:0] median_taps [MEDIAN_TAPS_DEF];
	logic [LUX_W-1:0] mean_ring [AVERAGE_WINDOW_DEF];
	int               ring_pos;
	logic [LUX_W-1:0] last_filtered;
	logic [PCT_W-1:0] held_pct;
	logic [LUX_W-1:0] dark_lux;
	logic [LUX_W-1:0] bright_lux;
	logic [PCT_W-1:0] band_pct;

	lux_reading_t pending_readings [$];
	int           mismatches = 0;
	int           samples_sent = 0;
	int           results_taken = 0;
	int           idle_cycles = 0;
	int           lux_level = 0;

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	function automatic lux_reading_t smooth_and_dim(input logic rdy,
			input logic [SAMPLE_W-1:0] raw);
		lux_reading_t     res;
		logic [LUX_W-1:0] sorted [MEDIAN_TAPS_DEF];
		logic [LUX_W-1:0] v;
		logic [63:0]      sum;
		logic [63:0]      scaled;
		logic [PCT_W-1:0] pct;
		logic [PCT_W-1:0] diff;
		int               j;
		res.accepted = 1'b0;
		if (rdy && !raw[SAMPLE_W-1] && raw[LUX_W-1:0] <= LUX_MAX) begin
			for (int i = MEDIAN_TAPS_DEF - 1; i > 0; i--)
				median_taps[i] = median_taps[i-1];
			median_taps[0] = raw[LUX_W-1:0];
			sorted = median_taps;
			for (int i = 1; i < MEDIAN_TAPS_DEF; i++) begin
				v = sorted[i];
				j = i;
				while (j > 0 && sorted[j-1] > v) begin
					sorted[j] = sorted[j-1];
					j--;
				end
				sorted[j] = v;
			end
			mean_ring[ring_pos] = sorted[MEDIAN_TAPS_DEF/2];
			ring_pos = (ring_pos + 1) % AVERAGE_WINDOW_DEF;
			sum = '0;
			for (int i = 0; i < AVERAGE_WINDOW_DEF; i++)
				sum += mean_ring[i];
			scaled = sum / AVERAGE_WINDOW_DEF;
			last_filtered = scaled[LUX_W-1:0];
			if (last_filtered <= dark_lux) begin
				pct = '0;
			end else if (last_filtered >= bright_lux) begin
				pct = FULL_SCALE;
			end else begin
				scaled = (64'(last_filtered - dark_lux) * 64'(FULL_SCALE)) /
					64'(bright_lux - dark_lux);
				pct = scaled[PCT_W-1:0];
			end
			diff = (pct > held_pct) ? pct - held_pct : held_pct - pct;
			if (diff > band_pct)
				held_pct = pct;
			res.accepted = 1'b1;
		end
		res.filtered_lux   = last_filtered;
		res.brightness_pct = held_pct;
		return res;
	endfunction

	task automatic offer_sample(input logic rdy, input logic [SAMPLE_W-1:0] lux,
			input logic typed, input lux_reading_t typed_res);
		int           gap;
		lux_reading_t predicted;
		gap = ((samples_sent / 50) % 5 == 3) ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			sample_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		predicted = smooth_and_dim(rdy, lux);
		pending_readings.push_back(typed ? typed_res : predicted);
		sample_if.valid        <= 1'b1;
		sample_if.sample_ready <= rdy;
		sample_if.lux_sample   <= lux;
		do @(posedge clk); while (!sample_if.ready);
		samples_sent++;
	endtask

	// Leave cfg valid high across a batch; the caller drops it afterward.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= value;
		do @(posedge clk); while (!cfg_if.ready);
		case (idx)
			CFG_DARK:   dark_lux   = value[LUX_W-1:0];
			CFG_BRIGHT: bright_lux = value[LUX_W-1:0];
			CFG_BAND:   band_pct   = value[PCT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic settle();
		sample_if.valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly runs of in-range samples jittering around a level near the
	// thresholds, so the median and average settle and the map lands mid-band.
	task automatic draw_sample(output logic rdy, output logic [SAMPLE_W-1:0] lux);
		int kind;
		int lo;
		int hi;
		int span;
		int jitter;
		int v;
		kind = $urandom_range(0, 99);
		lo   = (dark_lux < bright_lux) ? int'(dark_lux) : int'(bright_lux);
		hi   = (dark_lux < bright_lux) ? int'(bright_lux) : int'(dark_lux);
		if (hi > LUX_TOP) hi = LUX_TOP;
		if (lo > hi) lo = hi;
		span = hi - lo;
		rdy  = 1'b1;
		if (kind < 10) begin
			rdy = 1'b0;
			lux = SAMPLE_W'($urandom);
		end else if (kind < 15) begin
			lux = SAMPLE_W'($urandom) | 24'h800000;
		end else if (kind < 20) begin
			lux = SAMPLE_W'($urandom_range(LUX_TOP + 1, 24'h7FFFFF));
		end else if (kind < 25) begin
			lux = SAMPLE_W'($urandom_range(0, LUX_TOP));
		end else begin
			if ($urandom_range(0, 19) == 0) begin
				case ($urandom_range(0, 4))
					0: lux_level = 0;
					1: lux_level = LUX_TOP;
					default: begin
						lo = lo - span / 4;
						hi = hi + span / 4;
						if (lo < 0) lo = 0;
						if (hi > LUX_TOP) hi = LUX_TOP;
						lux_level = $urandom_range(lo, hi);
					end
				endcase
			end
			jitter = span / 32 + 16;
			v = lux_level + int'($urandom_range(0, 2 * jitter)) - jitter;
			if (v < 0) v = 0;
			if (v > LUX_TOP) v = LUX_TOP;
			lux = SAMPLE_W'(v);
		end
	endtask

	initial begin
		logic                rdy;
		logic [SAMPLE_W-1:0] lux;
		lux_reading_t        typed_res;
		dimmer_cfg_t         setting;
		arst_n                 <= 1'b0;
		sample_if.valid        <= 1'b0;
		sample_if.sample_ready <= 1'b0;
		sample_if.lux_sample   <= '0;
		cfg_if.valid           <= 1'b0;
		cfg_if.index           <= CFG_DARK;
		cfg_if.data            <= '0;
		foreach (median_taps[i]) median_taps[i] = '0;
		foreach (mean_ring[i]) mean_ring[i] = '0;
		ring_pos      = 0;
		last_filtered = '0;
		held_pct      = '0;
		dark_lux      = DARK_RST;
		bright_lux    = BRIGHT_RST;
		band_pct      = BAND_RST;
		lux_level     = int'(DARK_RST);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			typed_res.accepted       = directed_rows[i].accepted;
			typed_res.filtered_lux   = directed_rows[i].filtered_lux;
			typed_res.brightness_pct = directed_rows[i].brightness_pct;
			offer_sample(directed_rows[i].rdy, directed_rows[i].lux,
				directed_rows[i].typed, typed_res);
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p > 0) begin
				settle();
				if (p <= NUM_FIXED) begin
					setting = fixed_cfg[p-1];
				end else begin
					setting.dark   = CFG_DATA_W'($urandom_range(0, 6000000));
					setting.bright = setting.dark
						+ CFG_DATA_W'($urandom_range(1, 400000));
					setting.band   = CFG_DATA_W'($urandom_range(0, FULL_SCALE));
				end
				write_reg(CFG_DARK, setting.dark);
				write_reg(CFG_BRIGHT, setting.bright);
				write_reg(CFG_BAND, setting.band);
				// an unused index must leave every register alone
				if (p == 3 || p > NUM_FIXED)
					write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
				cfg_if.valid <= 1'b0;
			end
			repeat (ITEMS_PER_PHASE) begin
				draw_sample(rdy, lux);
				offer_sample(rdy, lux, 1'b0, typed_res);
			end
		end

		settle();
		if (mismatches == 0)
			$display("tb_lux_median_average_dimmer: PASS");
		else
			$display("tb_lux_median_average_dimmer: FAIL");
		$finish;
	end

	// Result side: random stalls, bursts with none, and one long hold-off so
	// the block backs up and stalls incoming requests.
	initial begin
		int stall;
		result_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = ((results_taken / 50) % 5 == 4) ? 0 : $urandom_range(0, 9);
			if (results_taken == HOLD_AT)
				stall = HOLD_CYCLES;
			if (stall > 0) begin
				result_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_if.ready <= 1'b1;
			do @(posedge clk); while (!result_if.valid);
			results_taken++;
		end
	end

	always @(posedge clk) begin
		lux_reading_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (pending_readings.size() == 0) begin
				report_mismatch($sformatf("unexpected result acc=%0b lux=%0d pct=%0d",
					result_if.accepted, result_if.filtered_lux,
					result_if.brightness_pct));
			end else begin
				want = pending_readings.pop_front();
				if (result_if.accepted !== want.accepted)
					report_mismatch($sformatf("accepted %0b, want %0b",
						result_if.accepted, want.accepted));
				if (result_if.filtered_lux !== want.filtered_lux)
					report_mismatch($sformatf("filtered_lux %0d, want %0d",
						result_if.filtered_lux, want.filtered_lux));
				if (result_if.brightness_pct !== want.brightness_pct)
					report_mismatch($sformatf("brightness_pct %0d, want %0d",
						result_if.brightness_pct, want.brightness_pct));
			end
		end
	end

	always @(posedge clk) begin
		if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready) ||
				(cfg_if.valid && cfg_if.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
			$display("tb_lux_median_average_dimmer: FAIL");
			$finish;
		end
	end

endmodule

// ----- filelist.f -----
rtl/lmad_pkg.sv
rtl/lmad_if.sv
rtl/lmad_median.sv
rtl/lmad_average.sv
rtl/lmad_map.sv
rtl/lux_median_average_dimmer.sv
rtl/lmad_checker.sv
tb/tb_lux_median_average_dimmer.sv
